// File: src/assert_macros.svh
// Assertion macros for the RTL of the open-slot table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SOT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define SOT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SOT_ASSERT(lbl, clk, rstn, prop, msg)
`define SOT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: src/sot_pkg.sv
// Types and constants of the shared open-slot table.
package sot_pkg;

  localparam int KEY_W       = 16;
  localparam int GRANT_W     = 4;
  localparam int CLOSE_IDX_W = 4;
  localparam int SOT_SLOTS   = 16;
  localparam int SOT_MAX_READERS = 255;

  localparam logic OP_OPEN  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_CONFLICT = 2'd2,
    STAT_LIMIT    = 2'd3
  } sot_status_e;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_CLAIM_RD,
    UPD_CLAIM_WR,
    UPD_ADD_READER,
    UPD_CLOSE
  } sot_upd_e;

  // Update command broadcast to all cells; only the selected cell acts on it.
  typedef struct packed {
    sot_upd_e         kind;
    logic [KEY_W-1:0] key;
  } sot_upd_t;

  // Flags of the search record that travels down the chain.
  typedef struct packed {
    logic hit;
    logic hit_wr;
    logic free;
  } sot_flags_t;

endpackage

// File: src/sot_cell.sv
// One slot of the table: slot state plus one stage of the search chain.
module sot_cell import sot_pkg::*; #(
  parameter int SLOT_ID = 0,
  parameter int IDX_W   = 4,
  parameter int SEL_W   = 4,
  parameter int CNT_W   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rec_vld_i,
  input  logic [KEY_W-1:0] rec_key_i,
  input  sot_flags_t       rec_flags_i,
  input  logic [IDX_W-1:0] rec_hit_idx_i,
  input  logic [CNT_W-1:0] rec_hit_cnt_i,
  input  logic [IDX_W-1:0] rec_free_idx_i,
  output logic             rec_vld_o,
  output logic [KEY_W-1:0] rec_key_o,
  output sot_flags_t       rec_flags_o,
  output logic [IDX_W-1:0] rec_hit_idx_o,
  output logic [CNT_W-1:0] rec_hit_cnt_o,
  output logic [IDX_W-1:0] rec_free_idx_o,
  input  sot_upd_t         upd_i,
  input  logic [SEL_W-1:0] upd_sel_i
);

  logic             in_use_q, in_use_d;
  logic             wr_q, wr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0] key_q;
  logic             key_we;
  logic             sel_me;
  logic             match;
  logic             take_free;

  logic             vld_q;
  logic [KEY_W-1:0] key_rec_q;
  sot_flags_t       flags_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q;
  logic [CNT_W-1:0] hit_cnt_q;

  assign sel_me = (upd_sel_i == SEL_W'(SLOT_ID));

  always_comb begin
    in_use_d = in_use_q;
    wr_d     = wr_q;
    cnt_d    = cnt_q;
    key_we   = 1'b0;
    if (sel_me) begin
      case (upd_i.kind)
        UPD_CLAIM_RD: begin
          in_use_d = 1'b1;
          wr_d     = 1'b0;
          cnt_d    = CNT_W'(1);
          key_we   = 1'b1;
        end
        UPD_CLAIM_WR: begin
          in_use_d = 1'b1;
          wr_d     = 1'b1;
          cnt_d    = '0;
          key_we   = 1'b1;
        end
        UPD_ADD_READER: begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        UPD_CLOSE: begin
          if (cnt_q > CNT_W'(1)) begin
            cnt_d = cnt_q - CNT_W'(1);
          end else begin
            in_use_d = 1'b0;
            wr_d     = 1'b0;
            cnt_d    = '0;
          end
        end
        default: begin
          in_use_d = in_use_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= 1'b0;
      wr_q     <= 1'b0;
      cnt_q    <= '0;
    end else begin
      in_use_q <= in_use_d;
      wr_q     <= wr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q <= upd_i.key;
    end
  end

  // A later matching cell overrides an earlier one, so the highest slot wins.
  assign match     = in_use_q && (key_q == rec_key_i);
  assign take_free = !in_use_q && !rec_flags_i.free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= rec_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_rec_q      <= rec_key_i;
    flags_q.hit    <= rec_flags_i.hit || match;
    flags_q.hit_wr <= match ? wr_q : rec_flags_i.hit_wr;
    flags_q.free   <= rec_flags_i.free || !in_use_q;
    hit_idx_q      <= match ? IDX_W'(SLOT_ID) : rec_hit_idx_i;
    hit_cnt_q      <= match ? cnt_q : rec_hit_cnt_i;
    free_idx_q     <= take_free ? IDX_W'(SLOT_ID) : rec_free_idx_i;
  end

  assign rec_vld_o      = vld_q;
  assign rec_key_o      = key_rec_q;
  assign rec_flags_o    = flags_q;
  assign rec_hit_idx_o  = hit_idx_q;
  assign rec_hit_cnt_o  = hit_cnt_q;
  assign rec_free_idx_o = free_idx_q;

endmodule

// File: src/shared_open_slot_table.sv
// Shared open-slot table: a row of slot cells searched by a record passed down the chain.
//
// Each slot lives in a cell of its own. An open request enters the first cell when it is
// accepted and moves one cell per clock, gathering the highest matching slot and the lowest
// free slot; when it leaves the last cell the decision is made and the chosen cell updated.
// An open therefore stays in work until its record has passed every cell, so its time in
// work is set by the length of the cell chain; a close updates its cell in S_CLOSE alone.
// busy is high while an item is in work. The result appears on granted_slot_o and
// status_o with done_o, which is high for exactly one cycle, and the receiver cannot
// stall it; a new item may be accepted while done_o is high. Closes beyond slot 15 are not
// possible, and granted_slot_o holds the low four bits of the slot number.
`include "assert_macros.svh"

module shared_open_slot_table import sot_pkg::*; #(
  parameter int SLOTS       = SOT_SLOTS,
  parameter int MAX_READERS = SOT_MAX_READERS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               opcode_i,
  input  logic [KEY_W-1:0]   object_key_i,
  input  logic               write_mode_i,
  input  logic [CLOSE_IDX_W-1:0] slot_index_i,
  output logic               done_o,
  output logic [GRANT_W-1:0] granted_slot_o,
  output logic [1:0]         status_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SEL_W = (IDX_W > CLOSE_IDX_W) ? IDX_W : CLOSE_IDX_W;
  localparam int CNT_W = $clog2(MAX_READERS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CLOSE
  } state_e;

  state_e                   state_q;
  logic                     wr_q;
  logic [CLOSE_IDX_W-1:0]   idx_q;
  logic                     done_q;
  logic [GRANT_W-1:0]       granted_q;
  sot_status_e              status_q;

  logic                     accept;
  logic                     ch_vld      [SLOTS+1];
  logic [KEY_W-1:0]         ch_key      [SLOTS+1];
  sot_flags_t               ch_flags    [SLOTS+1];
  logic [IDX_W-1:0]         ch_hit_idx  [SLOTS+1];
  logic [CNT_W-1:0]         ch_hit_cnt  [SLOTS+1];
  logic [IDX_W-1:0]         ch_free_idx [SLOTS+1];

  sot_upd_t                 upd;
  logic [SEL_W-1:0]         upd_sel;
  logic [SEL_W-1:0]         res_grant;
  sot_status_e              res_status;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // An open request enters the chain at the cycle it is accepted.
  assign ch_vld[0]      = accept && (opcode_i == OP_OPEN);
  assign ch_key[0]      = object_key_i;
  assign ch_flags[0]    = '0;
  assign ch_hit_idx[0]  = '0;
  assign ch_hit_cnt[0]  = '0;
  assign ch_free_idx[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    sot_cell #(
      .SLOT_ID(g),
      .IDX_W  (IDX_W),
      .SEL_W  (SEL_W),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .rec_vld_i     (ch_vld[g]),
      .rec_key_i     (ch_key[g]),
      .rec_flags_i   (ch_flags[g]),
      .rec_hit_idx_i (ch_hit_idx[g]),
      .rec_hit_cnt_i (ch_hit_cnt[g]),
      .rec_free_idx_i(ch_free_idx[g]),
      .rec_vld_o     (ch_vld[g+1]),
      .rec_key_o     (ch_key[g+1]),
      .rec_flags_o   (ch_flags[g+1]),
      .rec_hit_idx_o (ch_hit_idx[g+1]),
      .rec_hit_cnt_o (ch_hit_cnt[g+1]),
      .rec_free_idx_o(ch_free_idx[g+1]),
      .upd_i         (upd),
      .upd_sel_i     (upd_sel)
    );
  end

  always_comb begin
    upd.kind   = UPD_NONE;
    upd.key    = ch_key[SLOTS];
    upd_sel    = '0;
    res_grant  = '0;
    res_status = STAT_OK;
    case (state_q)
      S_SCAN: begin
        if (ch_vld[SLOTS]) begin
          if (ch_flags[SLOTS].hit) begin
            if (wr_q || ch_flags[SLOTS].hit_wr) begin
              res_status = STAT_CONFLICT;
            end else if (ch_hit_cnt[SLOTS] >= CNT_W'(MAX_READERS)) begin
              res_status = STAT_LIMIT;
            end else begin
              upd.kind  = UPD_ADD_READER;
              upd_sel   = SEL_W'(ch_hit_idx[SLOTS]);
              res_grant = SEL_W'(ch_hit_idx[SLOTS]);
            end
          end else if (ch_flags[SLOTS].free) begin
            upd.kind  = wr_q ? UPD_CLAIM_WR : UPD_CLAIM_RD;
            upd_sel   = SEL_W'(ch_free_idx[SLOTS]);
            res_grant = SEL_W'(ch_free_idx[SLOTS]);
          end else begin
            res_status = STAT_FULL;
          end
        end
      end
      S_CLOSE: begin
        upd.kind = UPD_CLOSE;
        upd_sel  = SEL_W'(idx_q);
      end
      default: begin
        upd.kind = UPD_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wr_q      <= 1'b0;
      idx_q     <= '0;
      done_q    <= 1'b0;
      granted_q <= '0;
      status_q  <= STAT_OK;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            wr_q    <= write_mode_i;
            idx_q   <= slot_index_i;
            state_q <= (opcode_i == OP_CLOSE) ? S_CLOSE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (ch_vld[SLOTS]) begin
            done_q    <= 1'b1;
            granted_q <= res_grant[GRANT_W-1:0];
            status_q  <= res_status;
            state_q   <= S_IDLE;
          end
        end
        S_CLOSE: begin
          done_q    <= 1'b1;
          granted_q <= '0;
          status_q  <= STAT_OK;
          state_q   <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign granted_slot_o = granted_q;
  assign status_o       = status_q;

  `SOT_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy, "result strobe while still busy")
  `SOT_ASSERT(a_tail_in_scan, clk_i, rst_ni, ch_vld[SLOTS] |-> (state_q == S_SCAN), "search record left chain outside a scan")
  `SOT_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> busy, "accepted item did not raise busy")
  `SOT_NEVER(a_refused_grant, clk_i, rst_ni, done_o && (status_o != STAT_OK) && (granted_slot_o != '0), "refused open reports a slot")

endmodule
